[hw/rtl/rmhp_pkg.sv]
// Shared types and constants for the routing cost grid painter.
// No dependencies; every other file of the block but rmhp_checker imports this package.
`timescale 1ns / 1ps

package rmhp_pkg;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  // Signed coordinate wide enough for 4095 + 255 rings and for -255.
  localparam int PW = 14;
  typedef logic signed [PW-1:0] coord_t;

  // Command codes.
  localparam logic [2:0] CMD_FILL = 3'd0;
  localparam logic [2:0] CMD_BOX  = 3'd1;
  localparam logic [2:0] CMD_VBR  = 3'd2;
  localparam logic [2:0] CMD_HBR  = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_GRID_COLS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [1:0] REG_SLACK     = 2'd2;
  localparam logic [1:0] REG_HALO      = 2'd3;

  localparam logic [8:0] RST_GRID_COLS = 9'd256;
  localparam logic [8:0] RST_GRID_ROWS = 9'd256;
  localparam logic [3:0] RST_SLACK     = 4'd1;
  localparam logic [7:0] RST_HALO      = 8'd8;

  // Operation applied to every cell of a swept rectangle.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOWER = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] val;
    coord_t     c_lo;
    coord_t     c_hi;
    coord_t     r_lo;
    coord_t     r_hi;
  } sweep_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rdata;
  } sweep_rsp_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] cell_value;
    logic       bad_command;
  } result_t;

endpackage

[hw/rtl/rmhp_sweep.sv]
// Rectangle sweep unit: holds the cost grid memory and walks one rectangle
// cell by cell, writing, lowering or reading. Depends on rmhp_pkg.
`timescale 1ns / 1ps

module rmhp_sweep #(
  parameter int MAX_COLS = rmhp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = rmhp_pkg::DEF_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmhp_pkg::sweep_req_t req,
  input  rmhp_pkg::coord_t    nc,
  input  rmhp_pkg::coord_t    nr,
  output rmhp_pkg::sweep_rsp_t rsp
);
  import rmhp_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);

  typedef enum logic [2:0] {
    SW_IDLE = 3'b001,
    SW_CELL = 3'b010,
    SW_MOD  = 3'b100
  } sw_state_t;

  sw_state_t  st_r, st_nxt;
  op_t        op_r;
  logic [7:0] val_r;
  coord_t     c_lo_r, c_hi_r, r_hi_r;
  coord_t     x_r, x_nxt, y_r, y_nxt;
  logic       done_r, done_nxt;
  logic [7:0] rdata_r;
  logic [7:0] mem [DEPTH];

  logic          in_grid, last, adv, we;
  logic [AW-1:0] addr;

  assign in_grid = (x_r >= 0) && (x_r < nc) && (y_r >= 0) && (y_r < nr);
  assign last    = (x_r == c_hi_r) && (y_r == r_hi_r);
  assign addr    = {y_r[RW-1:0], x_r[CW-1:0]};

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    done_nxt = 1'b0;
    adv      = 1'b0;
    we       = 1'b0;
    unique case (st_r)
      SW_IDLE: begin
        if (req.start) begin
          x_nxt = req.c_lo;
          y_nxt = req.r_lo;
          if (req.c_lo > req.c_hi || req.r_lo > req.r_hi) begin
            done_nxt = 1'b1;
          end else begin
            st_nxt = SW_CELL;
          end
        end
      end
      SW_CELL: begin
        if (op_r == OP_WRITE) begin
          we  = in_grid;
          adv = 1'b1;
        end else if (in_grid) begin
          st_nxt = SW_MOD;
        end else begin
          adv = 1'b1;
        end
      end
      SW_MOD: begin
        we  = (op_r == OP_LOWER) && (rdata_r > val_r);
        adv = 1'b1;
      end
      default: st_nxt = SW_IDLE;
    endcase
    if (adv) begin
      if (last) begin
        done_nxt = 1'b1;
        st_nxt   = SW_IDLE;
      end else if (x_r == c_hi_r) begin
        st_nxt = SW_CELL;
        x_nxt  = c_lo_r;
        y_nxt  = y_r + coord_t'(1);
      end else begin
        st_nxt = SW_CELL;
        x_nxt  = x_r + coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SW_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    if (st_r == SW_IDLE && req.start) begin
      op_r   <= req.op;
      val_r  <= req.val;
      c_lo_r <= req.c_lo;
      c_hi_r <= req.c_hi;
      r_hi_r <= req.r_hi;
    end
  end

  // Single-port grid memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= val_r;
    end
    if (st_r == SW_CELL) begin
      rdata_r <= mem[addr];
    end
  end

  assign rsp.done  = done_r;
  assign rsp.rdata = rdata_r;

endmodule

[hw/rtl/rmhp_seq.sv]
// Command sequencer: decodes one command and issues the chain of rectangle
// sweeps that carries it out. Depends on rmhp_pkg.
`timescale 1ns / 1ps

module rmhp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           cmd,
  input  logic [7:0]           c1,
  input  logic [7:0]           r1,
  input  logic [7:0]           c2,
  input  logic [7:0]           r2,
  input  logic [7:0]           fv,
  input  rmhp_pkg::coord_t     nc,
  input  rmhp_pkg::coord_t     nr,
  input  logic [3:0]           slack,
  input  logic [7:0]           halo,
  output rmhp_pkg::sweep_req_t req,
  input  rmhp_pkg::sweep_rsp_t rsp,
  output rmhp_pkg::result_t    res,
  input  logic                 res_ready
);
  import rmhp_pkg::*;

  typedef enum logic [7:0] {
    Q_IDLE   = 8'b0000_0001,
    Q_FILL   = 8'b0000_0010,
    Q_CLEAR  = 8'b0000_0100,
    Q_RING   = 8'b0000_1000,
    Q_BCLEAR = 8'b0001_0000,
    Q_BSTEP  = 8'b0010_0000,
    Q_READ   = 8'b0100_0000,
    Q_RESP   = 8'b1000_0000
  } seq_state_t;

  seq_state_t q_r, q_nxt;
  logic       pend_r, pend_nxt;
  logic       box_r, box_nxt;
  logic [7:0] fillv_r, fillv_nxt;
  coord_t     x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic [7:0] ring_r, ring_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       vert_r, vert_nxt, rev_r, rev_nxt;
  coord_t     a1_r, a1_nxt, a2_r, a2_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [7:0] step_r, step_nxt;
  logic [7:0] val_r, val_nxt;
  logic       bad_r, bad_nxt;

  coord_t c1s, r1s, c2s, r2s, s, a, b1, b2, na, nb, na_r, nb_r;
  coord_t a1_i, a2_i, lo_i, hi_i, ri;
  coord_t a1_u, a2_u, lo_u, hi_u;
  logic   rev_i, vert_i, bad_i, working;

  assign c1s    = coord_t'(c1);
  assign r1s    = coord_t'(r1);
  assign c2s    = coord_t'(c2);
  assign r2s    = coord_t'(r2);
  assign s      = coord_t'(slack);
  assign vert_i = (cmd == CMD_VBR);
  assign a      = vert_i ? c1s : r1s;
  assign b1     = vert_i ? r1s : c1s;
  assign b2     = vert_i ? r2s : c2s;
  assign na     = vert_i ? nc : nr;
  assign nb     = vert_i ? nr : nc;
  assign rev_i  = b1 > b2;

  // Initial branch window, widened by the slack and clipped to the grid.
  always_comb begin
    a1_i = a - s;
    a2_i = a + s;
    lo_i = rev_i ? b2 - s : b1 - s;
    hi_i = rev_i ? b1 + s : b2 + s;
    if (a1_i < 0) a1_i = '0;
    if (a2_i >= na) a2_i = na - coord_t'(1);
    if (lo_i < 0) lo_i = '0;
    if (hi_i >= nb) hi_i = nb - coord_t'(1);
  end

  // One move of the branch window: cross axis widens, line axis slides.
  assign na_r = vert_r ? nc : nr;
  assign nb_r = vert_r ? nr : nc;
  always_comb begin
    a1_u = (a1_r > 0) ? a1_r - coord_t'(1) : a1_r;
    a2_u = (a2_r < na_r - coord_t'(1)) ? a2_r + coord_t'(1) : a2_r;
    if (rev_r) begin
      lo_u = (lo_r < nb_r - coord_t'(1)) ? lo_r + coord_t'(1) : lo_r;
      hi_u = (hi_r < nb_r - coord_t'(1)) ? hi_r + coord_t'(1) : hi_r;
    end else begin
      lo_u = (lo_r > 0) ? lo_r - coord_t'(1) : lo_r;
      hi_u = (hi_r > 0) ? hi_r - coord_t'(1) : hi_r;
    end
  end

  always_comb begin
    unique case (cmd)
      CMD_FILL: bad_i = 1'b0;
      CMD_BOX:  bad_i = (c1s >= nc) || (c2s >= nc) || (r1s >= nr) || (r2s >= nr);
      CMD_VBR:  bad_i = (c1s >= nc) || (r1s >= nr) || (r2s >= nr);
      CMD_HBR:  bad_i = (r1s >= nr) || (c1s >= nc) || (c2s >= nc);
      CMD_READ: bad_i = (c1s >= nc) || (r1s >= nr);
      default:  bad_i = 1'b1;
    endcase
  end

  assign in_ready = (q_r == Q_IDLE);
  assign working  = (q_r == Q_FILL) || (q_r == Q_CLEAR) || (q_r == Q_RING) ||
                    (q_r == Q_BCLEAR) || (q_r == Q_BSTEP) || (q_r == Q_READ);
  assign ri       = coord_t'(ring_r);

  // Rectangle handed to the sweep unit in each phase.
  always_comb begin
    req.start = working && !pend_r;
    req.op    = OP_WRITE;
    req.val   = '0;
    req.c_lo  = '0;
    req.c_hi  = '0;
    req.r_lo  = '0;
    req.r_hi  = '0;
    unique case (q_r)
      Q_FILL: begin
        req.val  = fillv_r;
        req.c_hi = nc - coord_t'(1);
        req.r_hi = nr - coord_t'(1);
      end
      Q_CLEAR: begin
        req.c_lo = x0_r;
        req.c_hi = x1_r;
        req.r_lo = y0_r;
        req.r_hi = y1_r;
      end
      Q_RING: begin
        req.val = ring_r;
        unique case (seg_r)
          2'd0: begin
            req.c_lo = x0_r - ri; req.c_hi = x0_r - ri;
            req.r_lo = y0_r - ri; req.r_hi = y1_r + ri;
          end
          2'd1: begin
            req.c_lo = x1_r + ri; req.c_hi = x1_r + ri;
            req.r_lo = y0_r - ri; req.r_hi = y1_r + ri;
          end
          2'd2: begin
            req.c_lo = x0_r - ri; req.c_hi = x1_r + ri;
            req.r_lo = y0_r - ri; req.r_hi = y0_r - ri;
          end
          default: begin
            req.c_lo = x0_r - ri; req.c_hi = x1_r + ri;
            req.r_lo = y1_r + ri; req.r_hi = y1_r + ri;
          end
        endcase
      end
      Q_BCLEAR, Q_BSTEP: begin
        if (q_r == Q_BSTEP) begin
          req.op  = OP_LOWER;
          req.val = step_r;
        end
        if (vert_r) begin
          req.c_lo = a1_r; req.c_hi = a2_r; req.r_lo = lo_r; req.r_hi = hi_r;
        end else begin
          req.c_lo = lo_r; req.c_hi = hi_r; req.r_lo = a1_r; req.r_hi = a2_r;
        end
      end
      Q_READ: begin
        req.op   = OP_READ;
        req.c_lo = x0_r; req.c_hi = x0_r;
        req.r_lo = y0_r; req.r_hi = y0_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    q_nxt     = q_r;
    pend_nxt  = pend_r;
    box_nxt   = box_r;
    fillv_nxt = fillv_r;
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    ring_nxt  = ring_r;
    seg_nxt   = seg_r;
    vert_nxt  = vert_r;
    rev_nxt   = rev_r;
    a1_nxt = a1_r; a2_nxt = a2_r; lo_nxt = lo_r; hi_nxt = hi_r;
    step_nxt  = step_r;
    val_nxt   = val_r;
    bad_nxt   = bad_r;
    if (req.start) pend_nxt = 1'b1;
    if (working && rsp.done) pend_nxt = 1'b0;

    unique case (q_r)
      Q_IDLE: begin
        if (in_valid) begin
          x0_nxt = c1s; y0_nxt = r1s; x1_nxt = c2s; y1_nxt = r2s;
          vert_nxt = vert_i; rev_nxt = rev_i;
          a1_nxt = a1_i; a2_nxt = a2_i; lo_nxt = lo_i; hi_nxt = hi_i;
          val_nxt = '0;
          bad_nxt = bad_i;
          box_nxt = (cmd == CMD_BOX);
          fillv_nxt = (cmd == CMD_BOX) ? halo : fv;
          if (bad_i) begin
            q_nxt = Q_RESP;
          end else begin
            unique case (cmd)
              CMD_FILL, CMD_BOX: q_nxt = Q_FILL;
              CMD_VBR, CMD_HBR:  q_nxt = Q_BCLEAR;
              default:           q_nxt = Q_READ;
            endcase
          end
        end
      end
      Q_FILL: if (rsp.done) q_nxt = box_r ? Q_CLEAR : Q_RESP;
      Q_CLEAR: begin
        if (rsp.done) begin
          ring_nxt = 8'd1;
          seg_nxt  = 2'd0;
          q_nxt    = (halo != 8'd0) ? Q_RING : Q_RESP;
        end
      end
      Q_RING: begin
        if (rsp.done) begin
          if (seg_r != 2'd3) begin
            seg_nxt = seg_r + 2'd1;
          end else if (ring_r == halo) begin
            q_nxt = Q_RESP;
          end else begin
            ring_nxt = ring_r + 8'd1;
            seg_nxt  = 2'd0;
          end
        end
      end
      Q_BCLEAR: begin
        if (rsp.done) begin
          if (halo > 8'd1) begin
            step_nxt = 8'd1;
            a1_nxt = a1_u; a2_nxt = a2_u; lo_nxt = lo_u; hi_nxt = hi_u;
            q_nxt = Q_BSTEP;
          end else begin
            q_nxt = Q_RESP;
          end
        end
      end
      Q_BSTEP: begin
        if (rsp.done) begin
          if (({1'b0, step_r} + 9'd1) < {1'b0, halo}) begin
            step_nxt = step_r + 8'd1;
            a1_nxt = a1_u; a2_nxt = a2_u; lo_nxt = lo_u; hi_nxt = hi_u;
          end else begin
            q_nxt = Q_RESP;
          end
        end
      end
      Q_READ: begin
        if (rsp.done) begin
          val_nxt = rsp.rdata;
          q_nxt   = Q_RESP;
        end
      end
      Q_RESP: if (res_ready) q_nxt = Q_IDLE;
      default: q_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= Q_IDLE;
      pend_r <= 1'b0;
    end else begin
      q_r    <= q_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_r   <= box_nxt;
    fillv_r <= fillv_nxt;
    x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    ring_r  <= ring_nxt;
    seg_r   <= seg_nxt;
    vert_r  <= vert_nxt;
    rev_r   <= rev_nxt;
    a1_r <= a1_nxt; a2_r <= a2_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    step_r  <= step_nxt;
    val_r   <= val_nxt;
    bad_r   <= bad_nxt;
  end

  assign res.valid       = (q_r == Q_RESP);
  assign res.cell_value  = val_r;
  assign res.bad_command = bad_r;

endmodule

[hw/rtl/route_mask_halo_painter.sv]
// Top level of the routing cost grid painter: configuration registers,
// command sequencer, sweep unit with the grid memory, and the result register.
// Depends on rmhp_pkg, rmhp_seq and rmhp_sweep.
`timescale 1ns / 1ps

// The block keeps a byte-per-cell cost grid of MAX_COLS by MAX_ROWS cells in a
// single-port memory and executes one command per input word. A command is
// carried out by a single sweep unit that visits one cell per cycle when
// writing, so the time per word follows the area touched: a read visits one
// cell; fill sweeps the whole grid; box sweeps the whole grid for the
// background, then the rectangle, then, for each ring i up to halo_levels, the
// two column edges and two row edges of that ring (each edge walked in full,
// off-grid cells skipped); a branch clears its widened window and then, for
// each of the halo_levels-1 moves, reads and then conditionally writes each
// in-grid cell of the window. Rejected commands answer without a sweep. The
// input is not ready while a command runs; the result sits in an output
// register, so the next word is accepted while the previous result still waits.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and must only
// change while the block is idle. Grid cells never written read as undefined.
module route_mask_halo_painter #(
  parameter int MAX_COLS = rmhp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = rmhp_pkg::DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // first_col, first_row, second_col, second_row, fill_value
  input  logic [2:0]  in_tuser,   // command
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // cell_value
  output logic        out_tuser,  // bad_command
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);
  import rmhp_pkg::*;

  logic [8:0] cols_r, rows_r;
  logic [3:0] slack_r;
  logic [7:0] halo_r;
  coord_t     nc, nr;

  sweep_req_t req;
  sweep_rsp_t rsp;
  result_t    res;
  logic       res_ready;

  logic       out_valid_r;
  logic [7:0] out_value_r;
  logic       out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= RST_GRID_COLS;
      rows_r  <= RST_GRID_ROWS;
      slack_r <= RST_SLACK;
      halo_r  <= RST_HALO;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_COLS: cols_r  <= cfg_wdata;
        REG_GRID_ROWS: rows_r  <= cfg_wdata;
        REG_SLACK:     slack_r <= cfg_wdata[3:0];
        REG_HALO:      halo_r  <= cfg_wdata[7:0];
      endcase
    end
  end

  // Active grid size, clamped to one cell at least and to the memory size.
  always_comb begin
    if (cols_r == 9'd0) nc = coord_t'(1);
    else if (coord_t'(cols_r) > coord_t'(MAX_COLS)) nc = coord_t'(MAX_COLS);
    else nc = coord_t'(cols_r);
    if (rows_r == 9'd0) nr = coord_t'(1);
    else if (coord_t'(rows_r) > coord_t'(MAX_ROWS)) nr = coord_t'(MAX_ROWS);
    else nr = coord_t'(rows_r);
  end

  rmhp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .c1        (in_tdata[7:0]),
    .r1        (in_tdata[15:8]),
    .c2        (in_tdata[23:16]),
    .r2        (in_tdata[31:24]),
    .fv        (in_tdata[39:32]),
    .nc        (nc),
    .nr        (nr),
    .slack     (slack_r),
    .halo      (halo_r),
    .req       (req),
    .rsp       (rsp),
    .res       (res),
    .res_ready (res_ready)
  );

  rmhp_sweep #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .nc    (nc),
    .nr    (nr),
    .rsp   (rsp)
  );

  // Output register: a finished result waits here without holding the sequencer.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_value_r <= res.cell_value;
      out_bad_r   <= res.bad_command;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_bad_r;

endmodule

[hw/rtl/rmhp_checker.sv]
// Port-level checker for the routing cost grid painter, bound to the top level.
// Depends on route_mask_halo_painter's port list only.
`timescale 1ns / 1ps

module rmhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Every accepted command makes the block busy and drops its input ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accepting a word");

  // A rejected command never returns cell data.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("rejected command returned nonzero cell value");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind route_mask_halo_painter rmhp_checker u_rmhp_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for route_mask_halo_painter: a command stream with
// random idling on both sides, checked against a cost grid predictor.
// Depends on rmhp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import rmhp_pkg::*;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;

  // Lowest and highest command codes that the block does not know.
  localparam logic [2:0] CMD_UNK_LO = 3'd5;
  localparam logic [2:0] CMD_UNK_HI = 3'd7;

  // One command word as the block sees it.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] c1;
    logic [7:0] r1;
    logic [7:0] c2;
    logic [7:0] r2;
    logic [7:0] fv;
  } cmd_word_t;

  // One result word: the byte read back and the reject flag.
  typedef struct packed {
    logic [7:0] value;
    logic       bad;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // first_col, first_row, second_col, second_row, fill_value
  logic [2:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // cell_value
  logic        out_tuser;       // bad_command
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [8:0]  cfg_wdata = '0;

  route_mask_halo_painter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the grid and of the configuration registers.
  logic [7:0] cost_grid [0:GRID_W*GRID_H-1];
  int grid_cols_q = 256;
  int grid_rows_q = 256;
  int slack_q = 1;
  int halo_q = 8;

  cmd_word_t cmd_pending [$];
  answer_t   answer_due [$];
  int        fail_count = 0;
  int        in_burst = 0;
  int        out_burst = 0;
  int        in_gap = 0;

  // Idle draw for one word. Now and then a burst with no idling starts, so
  // that both back-to-back traffic and gaps of varied length occur.
  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  function automatic int used_cols();
    return (grid_cols_q < 1) ? 1 : (grid_cols_q > GRID_W) ? GRID_W : grid_cols_q;
  endfunction

  function automatic int used_rows();
    return (grid_rows_q < 1) ? 1 : (grid_rows_q > GRID_H) ? GRID_H : grid_rows_q;
  endfunction

  function automatic void set_cost(int c, int r, int nc, int nr, logic [7:0] v);
    if (c >= 0 && c < nc && r >= 0 && r < nr) cost_grid[r*GRID_W + c] = v;
  endfunction

  function automatic void flood_grid(int nc, int nr, logic [7:0] v);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) cost_grid[r*GRID_W + c] = v;
  endfunction

  // Box: background of halo, cleared rectangle, then ring i holds i.
  function automatic void paint_rings(int x0, int y0, int x1, int y1, int nc, int nr);
    flood_grid(nc, nr, halo_q[7:0]);
    for (int x = x0; x <= x1; x++)
      for (int y = y0; y <= y1; y++) cost_grid[y*GRID_W + x] = 8'd0;
    for (int i = 1; i <= halo_q; i++) begin
      for (int j = y0 - i; j <= y1 + i; j++) begin
        set_cost(x0 - i, j, nc, nr, i[7:0]);
        set_cost(x1 + i, j, nc, nr, i[7:0]);
      end
      for (int j = x0 - i; j <= x1 + i; j++) begin
        set_cost(j, y0 - i, nc, nr, i[7:0]);
        set_cost(j, y1 + i, nc, nr, i[7:0]);
      end
    end
  endfunction

  // Branch: clear the widened line, then slide the window halo-1 times and
  // lower every cell above the step number. a is the cross-axis position.
  function automatic void paint_trunk(bit vert, int a, int b1, int b2, int nc, int nr);
    int na, nb, a1, a2, lo, hi, idx;
    bit rev;
    na = vert ? nc : nr;
    nb = vert ? nr : nc;
    rev = (b1 > b2);
    a1 = a - slack_q;
    a2 = a + slack_q;
    lo = (rev ? b2 : b1) - slack_q;
    hi = (rev ? b1 : b2) + slack_q;
    if (a1 < 0) a1 = 0;
    if (a2 >= na) a2 = na - 1;
    if (lo < 0) lo = 0;
    if (hi >= nb) hi = nb - 1;
    for (int p = a1; p <= a2; p++)
      for (int q = lo; q <= hi; q++)
        cost_grid[vert ? q*GRID_W + p : p*GRID_W + q] = 8'd0;
    for (int v = 1; v < halo_q; v++) begin
      if (a1 > 0) a1--;
      if (a2 < na - 1) a2++;
      if (rev) begin
        if (lo < nb - 1) lo++;
        if (hi < nb - 1) hi++;
      end else begin
        if (lo > 0) lo--;
        if (hi > 0) hi--;
      end
      for (int p = a1; p <= a2; p++)
        for (int q = lo; q <= hi; q++) begin
          idx = vert ? q*GRID_W + p : p*GRID_W + q;
          if (cost_grid[idx] > v) cost_grid[idx] = v[7:0];
        end
    end
  endfunction

  // Applies one accepted command to the grid copy and returns its result.
  function automatic answer_t apply_command(cmd_word_t w);
    answer_t a;
    int nc, nr;
    nc = used_cols();
    nr = used_rows();
    a = '0;
    case (w.cmd)
      CMD_FILL: flood_grid(nc, nr, w.fv);
      CMD_BOX: begin
        if (w.c1 >= nc || w.c2 >= nc || w.r1 >= nr || w.r2 >= nr) a.bad = 1'b1;
        else paint_rings(w.c1, w.r1, w.c2, w.r2, nc, nr);
      end
      CMD_VBR: begin
        if (w.c1 >= nc || w.r1 >= nr || w.r2 >= nr) a.bad = 1'b1;
        else paint_trunk(1'b1, w.c1, w.r1, w.r2, nc, nr);
      end
      CMD_HBR: begin
        if (w.r1 >= nr || w.c1 >= nc || w.c2 >= nc) a.bad = 1'b1;
        else paint_trunk(1'b0, w.r1, w.c1, w.c2, nc, nr);
      end
      CMD_READ: begin
        if (w.c1 >= nc || w.r1 >= nr) a.bad = 1'b1;
        else a.value = cost_grid[w.r1*GRID_W + w.c1];
      end
      default: a.bad = 1'b1;
    endcase
    return a;
  endfunction

  // Driver: presents queued commands, predicting each one as it is taken.
  always @(posedge clk) begin : drive_commands
    cmd_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        answer_due.push_back(apply_command({in_tuser, in_tdata[7:0], in_tdata[15:8],
                                            in_tdata[23:16], in_tdata[31:24],
                                            in_tdata[39:32]}));
      if (in_tvalid && !in_tready) begin
        // Word still offered; hold it.
      end else if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (cmd_pending.size() > 0) begin
        w = cmd_pending.pop_front();
        in_tdata <= {w.fv, w.r2, w.c2, w.r1, w.c1};
        in_tuser <= w.cmd;
        in_tvalid <= 1'b1;
        in_gap <= draw_idle(in_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random stalls and checks them in order.
  // After the 200th word it stops taking results for a long stretch so the
  // block backs up and holds off its input.
  int out_wait = 0;
  int words_seen = 0;
  always @(posedge clk) begin : check_results
    answer_t e;
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if (answer_due.size() == 0) begin
        $error("result word with nothing expected: cell_value %0d bad_command %0d",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        e = answer_due.pop_front();
        if (out_tdata !== e.value) begin
          $error("cell_value expected %0d actual %0d", e.value, out_tdata);
          fail_count++;
        end
        if (out_tuser !== e.bad) begin
          $error("bad_command expected %0d actual %0d", e.bad, out_tuser);
          fail_count++;
        end
      end
      words_seen++;
      w = draw_idle(out_burst);
      if (words_seen == 200) w = 600;
      out_wait <= w;
      out_tready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_tready <= (out_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_cmd(logic [2:0] cmd, int c1, int r1, int c2, int r2, int fv);
    cmd_pending.push_back({cmd, c1[7:0], r1[7:0], c2[7:0], r2[7:0], fv[7:0]});
  endtask

  // Waits until every command is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_pending.size() != 0 || in_tvalid || answer_due.size() != 0);
  endtask

  task automatic program_grid(int cols, int rows, int slack, int halo);
    logic [8:0] vals [4];
    wait_idle();
    vals[0] = cols[8:0];
    vals[1] = rows[8:0];
    vals[2] = slack[8:0];
    vals[3] = halo[8:0];
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= i[1:0];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_cols_q = cols;
    grid_rows_q = rows;
    slack_q = slack;
    halo_q = halo;
  endtask

  // Mostly well-formed commands inside the grid; some coordinates run off
  // the grid and a few words carry unknown command codes.
  function automatic cmd_word_t random_cmd(bit boxes_ok);
    cmd_word_t w;
    int pick;
    int nc, nr;
    nc = used_cols();
    nr = used_rows();
    pick = $urandom_range(0, 99);
    if (pick < 8) w.cmd = CMD_FILL;
    else if (pick < 28) w.cmd = boxes_ok ? CMD_BOX : CMD_HBR;
    else if (pick < 48) w.cmd = CMD_VBR;
    else if (pick < 68) w.cmd = CMD_HBR;
    else if (pick < 94) w.cmd = CMD_READ;
    else w.cmd = 3'($urandom_range(CMD_UNK_LO, CMD_UNK_HI));
    w.c1 = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, nc-1));
    w.r1 = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, nr-1));
    w.c2 = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, nc-1));
    w.r2 = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, nr-1));
    w.fv = 8'($urandom_range(0, 255));
    return w;
  endfunction

  initial begin : stimulus
    int cols, rows;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid at reset settings. The first fill defines every cell, so no
    // later read can reach a cell that was never written.
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 8'hA5);
    queue_cmd(CMD_READ, 255, 255, 0, 0, 0);
    queue_cmd(CMD_VBR, 0, 250, 255, 3, 0);
    queue_cmd(CMD_HBR, 255, 128, 240, 0, 0);
    queue_cmd(CMD_READ, 0, 3, 0, 0, 0);
    queue_cmd(CMD_BOX, 100, 120, 110, 127, 0);
    queue_cmd(CMD_READ, 98, 125, 0, 0, 0);
    queue_cmd(CMD_UNK_LO, 255, 255, 255, 255, 255);
    queue_cmd(CMD_UNK_HI, 0, 0, 0, 0, 0);

    // Small grid: reversed box, spans off the grid, reversed branches.
    program_grid(16, 12, 2, 4);
    queue_cmd(CMD_BOX, 9, 8, 4, 3, 0);
    queue_cmd(CMD_READ, 6, 5, 0, 0, 0);
    queue_cmd(CMD_BOX, 0, 0, 16, 2, 0);
    queue_cmd(CMD_VBR, 15, 11, 0, 0, 0);
    queue_cmd(CMD_HBR, 15, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 15, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 12, 0, 0, 0);
    queue_cmd(CMD_HBR, 3, 12, 5, 0, 0);

    // No halo and no slack: box only clears, branch only clears its line.
    program_grid(10, 10, 0, 0);
    queue_cmd(CMD_BOX, 2, 2, 5, 5, 0);
    queue_cmd(CMD_VBR, 7, 1, 0, 8, 0);
    queue_cmd(CMD_READ, 9, 9, 0, 0, 0);

    // Single cell grid with the widest slack.
    program_grid(1, 1, 15, 3);
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 0);
    queue_cmd(CMD_HBR, 0, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0, 0, 0);

    // Deepest halo on a tiny grid; one box only, as rings are walked in full.
    program_grid(3, 4, 15, 255);
    queue_cmd(CMD_BOX, 1, 1, 1, 2, 0);
    for (int i = 0; i < 12; i++) cmd_pending.push_back(random_cmd(1'b0));

    // Random phases with small grids so that each command stays cheap.
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 5))
        0: begin cols = 1; rows = $urandom_range(1, 12); end
        1: begin cols = $urandom_range(20, 48); rows = $urandom_range(1, 4); end
        default: begin cols = $urandom_range(2, 12); rows = $urandom_range(2, 12); end
      endcase
      program_grid(cols, rows, $urandom_range(0, 15),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6));
      for (int i = 0; i < 82; i++) cmd_pending.push_back(random_cmd(1'b1));
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[route_mask_halo_painter.f]
hw/rtl/rmhp_pkg.sv
hw/rtl/rmhp_sweep.sv
hw/rtl/rmhp_seq.sv
hw/rtl/route_mask_halo_painter.sv
hw/rtl/rmhp_checker.sv
verif/tb_top.sv
